@@ src/mmss_pkg.sv @@
// Shared types, constants and segment decoding for the mm:ss countdown timer.
`timescale 1ns / 1ps
`default_nettype none

package mmss_pkg;

  localparam logic [3:0] KEY_POUND   = 4'd10;
  localparam logic [3:0] BLANK_DIGIT = 4'd10;
  localparam logic [3:0] MAX_DIGIT   = 4'd9;
  localparam logic [3:0] MAX_TENS_S  = 4'd5;
  localparam logic [9:0] TPS_RESET   = 10'd1000;
  localparam logic [7:0] SEG_BLANK   = 8'hFF;
  localparam logic [7:0] DP_ON_MASK  = 8'h7F;
  localparam logic [3:0] SEL_RESET   = 4'b0001;

  // One result item as driven on the output side.
  typedef struct packed {
    logic [3:0] digit_select;
    logic [7:0] segments;
    logic       run_mode;
    logic       alarm;
  } result_t;

  // Active-low seven-segment pattern; anything outside 0..9 shows blank.
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'hC0;
      4'd1:    pat = 8'hF9;
      4'd2:    pat = 8'hA4;
      4'd3:    pat = 8'hB0;
      4'd4:    pat = 8'h99;
      4'd5:    pat = 8'h92;
      4'd6:    pat = 8'h82;
      4'd7:    pat = 8'hF8;
      4'd8:    pat = 8'h80;
      4'd9:    pat = 8'h90;
      default: pat = SEG_BLANK;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

@@ src/mmss_countdown_timer_display.sv @@
// Minutes:seconds countdown timer with multiplexed seven-segment display output.
// Each result item is registered in the result register, or in the skid while the output is stalled.
// Throughput: one item per cycle while the skid is empty; the whole update is one pass of shallow logic.
// A two-entry output stage (result register plus skid) lets input flow while a result waits.
// Reset (synchronous, active high): digits zero, set mode, alarm clear, tick count zero,
// rightmost digit selected, segments off, ticks per second 1000, output stage empty.
`timescale 1ns / 1ps
`default_nettype none

module mmss_countdown_timer_display (
  input  wire logic       clk,
  input  wire logic       rst,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       func,
  input  wire logic [3:0] key_code,
  // output channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      digit_select,
  output logic [7:0]      segments,
  output logic            run_mode,
  output logic            alarm,
  // configuration
  input  wire logic       cfg_wr_en,
  input  wire logic [9:0] cfg_wr_data
);

  // ---------------------------------------------------------------------------
  // Timer state
  // ---------------------------------------------------------------------------
  logic [3:0] digits [4];        // 0 units s, 1 tens s, 2 units min, 3 tens min
  logic [3:0] digits_next [4];
  logic       counting, counting_next;
  logic       alarm_latched, alarm_latched_next;
  logic [9:0] tick_count, tick_count_next;
  logic [3:0] sel, sel_next;
  logic [7:0] seg_latch, seg_latch_next;
  logic [9:0] ticks_per_second;

  logic       accept;
  logic       take;
  logic       all_zero;
  logic [1:0] pos;
  logic [7:0] pat;
  logic [9:0] tick_inc;

  mmss_pkg::result_t result;
  mmss_pkg::result_t out_reg;
  mmss_pkg::result_t skid;
  logic              skid_valid;

  // Stall the input only while the skid holds a result; the result register
  // alone never blocks an item.
  assign in_stall = skid_valid;
  assign accept   = in_valid & ~skid_valid;
  assign take     = out_valid & ~out_stall;

  assign all_zero = (digits[0] == 4'd0) && (digits[1] == 4'd0) &&
                    (digits[2] == 4'd0) && (digits[3] == 4'd0);

  // ---------------------------------------------------------------------------
  // Single-pass update for one item
  // ---------------------------------------------------------------------------
  always_comb begin
    digits_next        = digits;
    counting_next      = counting;
    alarm_latched_next = alarm_latched;
    tick_count_next    = tick_count;
    sel_next           = sel;
    seg_latch_next     = seg_latch;
    pos                = 2'd0;
    pat                = mmss_pkg::SEG_BLANK;
    tick_inc           = tick_count + 10'd1;

    if (!func) begin
      // Tick: rotate the digit select and latch that digit's pattern,
      // taken from the digits as they stand before any countdown.
      sel_next = {sel[2:0], sel[3]};
      if (sel_next[1]) begin
        pos = 2'd1;
      end else if (sel_next[2]) begin
        pos = 2'd2;
      end else if (sel_next[3]) begin
        pos = 2'd3;
      end
      pat = mmss_pkg::seg_pattern(digits[pos]);
      // Light the decimal points on the two middle digits (the colon).
      if (pos == 2'd1 || pos == 2'd2) begin
        pat = pat & mmss_pkg::DP_ON_MASK;
      end
      seg_latch_next = pat;

      if (counting) begin
        tick_count_next = tick_inc;
        if (all_zero) begin
          alarm_latched_next = 1'b1;
        end
        if (tick_inc == ticks_per_second) begin
          tick_count_next = 10'd0;
          if (alarm_latched_next) begin
            // Blink: zero digits go blank, anything else back to zero.
            for (int i = 0; i < 4; i++) begin
              digits_next[i] = (digits[i] == 4'd0) ? mmss_pkg::BLANK_DIGIT : 4'd0;
            end
          end else if (digits[0] != 4'd0) begin
            digits_next[0] = digits[0] - 4'd1;
          end else if (digits[1] != 4'd0) begin
            digits_next[1] = digits[1] - 4'd1;
            digits_next[0] = mmss_pkg::MAX_DIGIT;
          end else if (digits[2] != 4'd0) begin
            digits_next[2] = digits[2] - 4'd1;
            digits_next[1] = mmss_pkg::MAX_TENS_S;
            digits_next[0] = mmss_pkg::MAX_DIGIT;
          end else if (digits[3] != 4'd0) begin
            digits_next[3] = digits[3] - 4'd1;
            digits_next[2] = mmss_pkg::MAX_DIGIT;
            digits_next[1] = mmss_pkg::MAX_TENS_S;
            digits_next[0] = mmss_pkg::MAX_DIGIT;
          end
        end
      end
    end else if (!counting) begin
      // Key in set mode: drop the alarm, shift a digit in or start running.
      alarm_latched_next = 1'b0;
      if (key_code <= mmss_pkg::MAX_DIGIT) begin
        digits_next[3] = digits[2];
        digits_next[2] = digits[1];
        digits_next[1] = digits[0];
        digits_next[0] = key_code;
      end else if (key_code == mmss_pkg::KEY_POUND) begin
        counting_next = 1'b1;
      end
    end else if (key_code == mmss_pkg::KEY_POUND) begin
      // Pound in run mode: back to set mode, wiping the display after an alarm.
      if (alarm_latched) begin
        for (int i = 0; i < 4; i++) begin
          digits_next[i] = 4'd0;
        end
      end
      alarm_latched_next = 1'b0;
      counting_next      = 1'b0;
    end
  end

  always_comb begin
    result.digit_select = sel_next;
    result.segments     = seg_latch_next;
    result.run_mode     = counting_next;
    result.alarm        = alarm_latched_next;
  end

  // Advance the state on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        digits[i] <= 4'd0;
      end
      counting      <= 1'b0;
      alarm_latched <= 1'b0;
      tick_count    <= 10'd0;
      sel           <= mmss_pkg::SEL_RESET;
      seg_latch     <= mmss_pkg::SEG_BLANK;
    end else if (accept) begin
      digits        <= digits_next;
      counting      <= counting_next;
      alarm_latched <= alarm_latched_next;
      tick_count    <= tick_count_next;
      sel           <= sel_next;
      seg_latch     <= seg_latch_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= mmss_pkg::TPS_RESET;
    end else if (cfg_wr_en) begin
      ticks_per_second <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: result register with a one-entry skid behind it
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // No item is accepted here; move the skid forward once the output drains.
      if (take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_reg <= skid;
      end
    end else if (accept) begin
      if (!out_valid || take) begin
        out_reg <= result;
      end else begin
        skid <= result;
      end
    end
  end

  assign digit_select = out_reg.digit_select;
  assign segments     = out_reg.segments;
  assign run_mode     = out_reg.run_mode;
  assign alarm        = out_reg.alarm;

`ifndef ASSERT_OFF
  // A held skid entry always has a result in front of it.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while the result register is empty");

  // The digit select stays one-hot through every rotation.
  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(sel))
    else $error("digit select lost its one-hot form");

  // The alarm can only stand while counting.
  a_alarm_in_run: assert property (@(posedge clk) disable iff (rst)
    alarm_latched |-> counting)
    else $error("alarm latched in set mode");

  // Digits hold 0..9 or the blank code, never anything beyond.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (digits[0] <= mmss_pkg::BLANK_DIGIT) && (digits[1] <= mmss_pkg::BLANK_DIGIT) &&
    (digits[2] <= mmss_pkg::BLANK_DIGIT) && (digits[3] <= mmss_pkg::BLANK_DIGIT))
    else $error("time digit out of range");
`endif

endmodule

`default_nettype wire
